// ===== rtl/cpts_pkg.sv =====
// ----------------------------------------------------------------------------
// cpts_pkg
// Shared types, constants and helpers for the counter priority task scheduler.
// ----------------------------------------------------------------------------
package cpts_pkg;

	// table geometry
	localparam int MAX_TASKS = 16;
	localparam int IDX_W     = $clog2(MAX_TASKS);
	localparam int SLOT_W    = 4;
	localparam int OP_W      = 3;
	localparam int PRI_W     = 8;
	localparam int PC_W      = 8;
	localparam int CNT_W     = 9;

	localparam logic [PRI_W-1:0] INIT_PRIO = PRI_W'(1);
	localparam logic [CNT_W-1:0] CNT_MAX   = {CNT_W{1'b1}};
	localparam logic [PC_W-1:0]  PC_MAX    = {PC_W{1'b1}};

	// operation codes
	localparam logic [OP_W-1:0] OP_TICK   = 3'd0;
	localparam logic [OP_W-1:0] OP_YIELD  = 3'd1;
	localparam logic [OP_W-1:0] OP_PC_DIS = 3'd2;
	localparam logic [OP_W-1:0] OP_PC_EN  = 3'd3;
	localparam logic [OP_W-1:0] OP_ADD    = 3'd4;
	localparam logic [OP_W-1:0] OP_TERM   = 3'd5;

	// one slot as read from the table
	typedef struct packed {
		logic             run;
		logic [CNT_W-1:0] cnt;
		logic [PRI_W-1:0] pri;
		logic [PC_W-1:0]  pc;
	} tbl_entry_t;

	// field writes into the addressed slot
	typedef struct packed {
		logic             run_en;
		logic             run;
		logic             cnt_en;
		logic [CNT_W-1:0] cnt;
		logic             pri_en;
		logic [PRI_W-1:0] pri;
		logic             pc_en;
		logic [PC_W-1:0]  pc;
	} tbl_wr_t;

	function automatic logic [PC_W-1:0] pc_sat_inc(input logic [PC_W-1:0] v);
		pc_sat_inc = (v == PC_MAX) ? v : v + PC_W'(1);
	endfunction

	function automatic logic [PC_W-1:0] pc_sat_dec(input logic [PC_W-1:0] v);
		pc_sat_dec = (v == '0) ? v : v - PC_W'(1);
	endfunction

endpackage

// ===== rtl/cpts_if.sv =====
// ----------------------------------------------------------------------------
// cpts_if
// Valid/ready channels for scheduler requests and scheduler results.
// ----------------------------------------------------------------------------
interface cpts_req_if;
	logic       valid;
	logic       ready;
	logic [2:0] opcode;
	logic [3:0] task_slot;
	logic [7:0] task_priority;

	modport source (output valid, output opcode, output task_slot,
		output task_priority, input ready);
	modport sink (input valid, input opcode, input task_slot,
		input task_priority, output ready);
endinterface

interface cpts_rsp_if;
	logic       valid;
	logic       ready;
	logic [3:0] current_task;
	logic [3:0] previous_task;
	logic       switched;
	logic       task_found;

	modport source (output valid, output current_task, output previous_task,
		output switched, output task_found, input ready);
	modport sink (input valid, input current_task, input previous_task,
		input switched, input task_found, output ready);
endinterface

// ===== rtl/counter_priority_task_scheduler.sv =====
// ----------------------------------------------------------------------------
// counter_priority_task_scheduler
// Sequence: a request is accepted in idle and executed; a reschedule then scans
// all slots, refills the running counters and scans again when all are spent.
// Throughput: one request at a time; the next is accepted after the result is
// registered, which waits while an untaken result is still held.
// Reset (async, active low): slot zero runs with priority 1, all else clear.
// ----------------------------------------------------------------------------
module counter_priority_task_scheduler
	import cpts_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	cpts_req_if.sink         task_req,
	cpts_rsp_if.source       sched_rsp,
	input  logic             cfg_wr_en,
	input  logic [PRI_W-1:0] cfg_wr_data
);

	typedef enum logic [2:0] {
		ST_IDLE, ST_EXEC, ST_INC, ST_SCAN, ST_REFILL, ST_DEC, ST_DONE
	} state_t;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_TASKS - 1);

	state_t            state_q;
	logic [OP_W-1:0]   op_q;
	logic [SLOT_W-1:0] slot_q;
	logic [PRI_W-1:0]  prio_q;
	logic [IDX_W-1:0]  cur_q;
	logic [IDX_W-1:0]  prev_q;
	logic [IDX_W-1:0]  idx_q;
	logic [IDX_W-1:0]  pick_q;
	logic [CNT_W-1:0]  best_q;
	logic              found_q;
	logic              pass2_q;
	logic              out_valid_q;
	logic [SLOT_W-1:0] out_cur_q;
	logic [SLOT_W-1:0] out_prev_q;
	logic              out_sw_q;
	logic              out_found_q;

	logic [IDX_W-1:0]  addr;
	tbl_wr_t           wr;
	tbl_entry_t        ent;
	logic              take;
	logic              found_n;
	logic [CNT_W-1:0]  best_n;
	logic [IDX_W-1:0]  pick_n;
	logic [IDX_W-1:0]  fin_idx;
	logic [CNT_W-1:0]  dec_cnt;
	logic [CNT_W:0]    refill_sum;
	logic [CNT_W-1:0]  refill_cnt;
	logic [PRI_W-1:0]  add_pri;
	logic              add_ok;
	logic              out_free;

	cpts_table u_table (
		.clk         (clk),
		.arst_n      (arst_n),
		.addr        (addr),
		.wr          (wr),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.rd          (ent)
	);

	// shared compare unit for the max scan
	assign take    = ent.run && (!found_q || (ent.cnt > best_q));
	assign found_n = found_q | take;
	assign best_n  = take ? ent.cnt : best_q;
	assign pick_n  = take ? idx_q : pick_q;
	assign fin_idx = found_q ? pick_q : cur_q;

	// counter arithmetic
	assign dec_cnt    = (ent.cnt != '0) ? ent.cnt - CNT_W'(1) : '0;
	assign refill_sum = (CNT_W + 1)'(ent.cnt >> 1) + (CNT_W + 1)'(ent.pri);
	assign refill_cnt = (refill_sum > (CNT_W + 1)'(CNT_MAX)) ? CNT_MAX
		: refill_sum[CNT_W-1:0];
	assign add_pri    = (prio_q == '0) ? PRI_W'(1) : prio_q;
	assign add_ok     = (32'(slot_q) < MAX_TASKS) && !ent.run;
	assign out_free   = !out_valid_q || sched_rsp.ready;

	// table address and writes per sequencer step
	always_comb begin
		wr   = '0;
		addr = cur_q;
		unique case (state_q)
			ST_EXEC: begin
				addr = (op_q == OP_ADD) ? IDX_W'(slot_q) : cur_q;
				unique case (op_q)
					OP_TICK: begin
						wr.cnt_en = 1'b1;
						wr.cnt    = dec_cnt;
					end
					OP_YIELD: begin
						wr.cnt_en = 1'b1;
						wr.cnt    = '0;
					end
					OP_PC_DIS: begin
						wr.pc_en = 1'b1;
						wr.pc    = pc_sat_inc(ent.pc);
					end
					OP_PC_EN: begin
						wr.pc_en = 1'b1;
						wr.pc    = pc_sat_dec(ent.pc);
					end
					OP_ADD: begin
						if (add_ok) begin
							wr.run_en = 1'b1;
							wr.run    = 1'b1;
							wr.pri_en = 1'b1;
							wr.pri    = add_pri;
							wr.cnt_en = 1'b1;
							wr.cnt    = CNT_W'(add_pri);
							wr.pc_en  = 1'b1;
							wr.pc     = PC_W'(1);
						end
					end
					OP_TERM: begin
						wr.run_en = 1'b1;
						wr.run    = 1'b0;
						wr.pc_en  = 1'b1;
						wr.pc     = pc_sat_dec(pc_sat_inc(ent.pc));
					end
					default: begin
					end
				endcase
			end
			ST_INC: begin
				wr.pc_en = 1'b1;
				wr.pc    = pc_sat_inc(ent.pc);
			end
			ST_SCAN: begin
				addr = idx_q;
			end
			ST_REFILL: begin
				addr      = idx_q;
				wr.cnt_en = ent.run;
				wr.cnt    = refill_cnt;
			end
			ST_DEC: begin
				addr     = fin_idx;
				wr.pc_en = 1'b1;
				wr.pc    = pc_sat_dec(ent.pc);
			end
			default: begin
			end
		endcase
	end

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cur_q       <= '0;
			out_valid_q <= 1'b0;
			op_q        <= '0;
			slot_q      <= '0;
			prio_q      <= '0;
			prev_q      <= '0;
			idx_q       <= '0;
			pick_q      <= '0;
			best_q      <= '0;
			found_q     <= 1'b0;
			pass2_q     <= 1'b0;
			out_cur_q   <= '0;
			out_prev_q  <= '0;
			out_sw_q    <= 1'b0;
			out_found_q <= 1'b0;
		end else begin
			// result valid: loaded by the completion step, cleared when taken
			if ((state_q == ST_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (sched_rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (task_req.valid) begin
						op_q    <= task_req.opcode;
						slot_q  <= task_req.task_slot;
						prio_q  <= task_req.task_priority;
						prev_q  <= cur_q;
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					found_q <= 1'b1;
					if ((op_q == OP_YIELD) || ((op_q == OP_TICK) && (dec_cnt == '0)
							&& (ent.pc == '0))) begin
						state_q <= ST_INC;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_INC: begin
					idx_q   <= '0;
					found_q <= 1'b0;
					best_q  <= '0;
					pick_q  <= '0;
					pass2_q <= 1'b0;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					idx_q   <= idx_q + IDX_W'(1);
					found_q <= found_n;
					best_q  <= best_n;
					pick_q  <= pick_n;
					if (idx_q == LAST_IDX) begin
						idx_q <= '0;
						if (found_n && (best_n == '0) && !pass2_q) begin
							state_q <= ST_REFILL;
						end else begin
							state_q <= ST_DEC;
						end
					end
				end
				ST_REFILL: begin
					idx_q <= idx_q + IDX_W'(1);
					if (idx_q == LAST_IDX) begin
						idx_q   <= '0;
						found_q <= 1'b0;
						best_q  <= '0;
						pick_q  <= '0;
						pass2_q <= 1'b1;
						state_q <= ST_SCAN;
					end
				end
				ST_DEC: begin
					cur_q   <= fin_idx;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						out_cur_q   <= SLOT_W'(cur_q);
						out_prev_q  <= SLOT_W'(prev_q);
						out_sw_q    <= (cur_q != prev_q);
						out_found_q <= found_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// channel outputs
	assign task_req.ready          = (state_q == ST_IDLE);
	assign sched_rsp.valid         = out_valid_q;
	assign sched_rsp.current_task  = out_cur_q;
	assign sched_rsp.previous_task = out_prev_q;
	assign sched_rsp.switched      = out_sw_q;
	assign sched_rsp.task_found    = out_found_q;

`ifndef SYNTHESIS
	// one request in flight: no accept in the cycle after an accept
	a_single_req: assert property (@(posedge clk) disable iff (!arst_n)
		(task_req.valid && task_req.ready) |=> !task_req.ready)
		else $error("request accepted while busy");

	// a result only appears out of the completion step
	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(sched_rsp.valid) |-> $past(state_q == ST_DONE))
		else $error("result raised outside completion step");

	// a switch implies a running task was found
	a_switch_found: assert property (@(posedge clk) disable iff (!arst_n)
		(sched_rsp.valid && sched_rsp.switched) |-> sched_rsp.task_found)
		else $error("switch reported without a found task");

	// the scan index is back at zero whenever a new scan pass starts
	a_scan_start: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_SCAN) && ($past(state_q) != ST_SCAN)) |-> (idx_q == '0))
		else $error("scan started at a nonzero slot");
`endif

endmodule

// ===== rtl/cpts_table.sv =====
// ----------------------------------------------------------------------------
// cpts_table
// Task slot table: running flag, time slice counter, priority and preempt
// count per slot, with one shared read/write address.
// ----------------------------------------------------------------------------
module cpts_table
	import cpts_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [IDX_W-1:0]     addr,
	input  tbl_wr_t              wr,
	input  logic                 cfg_wr_en,
	input  logic [PRI_W-1:0]     cfg_wr_data,
	output tbl_entry_t           rd
);

	logic             run_q [MAX_TASKS];
	logic [CNT_W-1:0] cnt_q [MAX_TASKS];
	logic [PRI_W-1:0] pri_q [MAX_TASKS];
	logic [PC_W-1:0]  pc_q  [MAX_TASKS];

	// read port
	always_comb begin
		rd.run = run_q[addr];
		rd.cnt = cnt_q[addr];
		rd.pri = pri_q[addr];
		rd.pc  = pc_q[addr];
	end

	// write port, config loads slot zero priority directly
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_TASKS; i++) begin
				run_q[i] <= (i == 0);
				cnt_q[i] <= '0;
				pri_q[i] <= (i == 0) ? INIT_PRIO : '0;
				pc_q[i]  <= '0;
			end
		end else begin
			if (wr.run_en) run_q[addr] <= wr.run;
			if (wr.cnt_en) cnt_q[addr] <= wr.cnt;
			if (wr.pri_en) pri_q[addr] <= wr.pri;
			if (wr.pc_en)  pc_q[addr]  <= wr.pc;
			if (cfg_wr_en) pri_q[0]    <= cfg_wr_data;
		end
	end

endmodule

// ===== tb/cpts_sched_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpts_sched_checker
// Watches the request and result channels of the task scheduler, keeps its
// own copy of the task table, predicts one result per accepted request and
// compares every accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
module cpts_sched_checker
	import cpts_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	cpts_req_if              req,
	cpts_rsp_if              rsp,
	input  logic             cfg_wr_en,
	input  logic [PRI_W-1:0] cfg_wr_data,
	output int               fail_count,
	output int               pending
);

	typedef struct packed {
		logic [SLOT_W-1:0] cur;
		logic [SLOT_W-1:0] prev;
		logic              sw;
		logic              found;
	} sched_result_t;

	// shadow task table
	logic             slot_run [MAX_TASKS];
	logic [CNT_W-1:0] slot_cnt [MAX_TASKS];
	logic [PRI_W-1:0] slot_pri [MAX_TASKS];
	logic [PC_W-1:0]  slot_pc  [MAX_TASKS];
	logic [SLOT_W-1:0] cur_slot;
	logic [PRI_W-1:0] init_pri;

	sched_result_t expected_results[$];

	function automatic logic [PC_W-1:0] pc_up(input logic [PC_W-1:0] v);
		return (v == PC_MAX) ? v : v + PC_W'(1);
	endfunction

	function automatic logic [PC_W-1:0] pc_down(input logic [PC_W-1:0] v);
		return (v == '0) ? v : v - PC_W'(1);
	endfunction

	// highest counter among running slots, lowest slot wins a tie
	function automatic int busiest_slot(output logic [SLOT_W-1:0] pick);
		int best;
		best = -1;
		pick = '0;
		for (int i = 0; i < MAX_TASKS; i++) begin
			if (slot_run[i] && int'(slot_cnt[i]) > best) begin
				best = int'(slot_cnt[i]);
				pick = SLOT_W'(i);
			end
		end
		return best;
	endfunction

	// reschedule, returns 1 when a running slot was found
	function automatic logic pick_next_task();
		int                best;
		logic [SLOT_W-1:0] pick;
		logic [CNT_W:0]    refill;
		slot_pc[cur_slot] = pc_up(slot_pc[cur_slot]);
		best = busiest_slot(pick);
		if (best < 0) begin
			slot_pc[cur_slot] = pc_down(slot_pc[cur_slot]);
			return 1'b0;
		end
		// every running counter spent: refill and pick again
		if (best == 0) begin
			for (int i = 0; i < MAX_TASKS; i++) begin
				if (slot_run[i]) begin
					refill = {2'b00, slot_cnt[i][CNT_W-1:1]}
						+ (CNT_W+1)'(slot_pri[i]);
					slot_cnt[i] = (refill > (CNT_W+1)'(CNT_MAX)) ? CNT_MAX
						: refill[CNT_W-1:0];
				end
			end
			best = busiest_slot(pick);
		end
		cur_slot = pick;
		slot_pc[cur_slot] = pc_down(slot_pc[cur_slot]);
		return 1'b1;
	endfunction

	// apply one request to the shadow table
	function automatic sched_result_t schedule_step(input logic [OP_W-1:0] op,
		input logic [SLOT_W-1:0] slot, input logic [PRI_W-1:0] pri);
		sched_result_t r;
		logic [SLOT_W-1:0] prev;
		logic found;
		prev = cur_slot;
		found = 1'b1;
		case (op)
			OP_TICK: begin
				if (slot_cnt[cur_slot] != '0)
					slot_cnt[cur_slot] = slot_cnt[cur_slot] - CNT_W'(1);
				if (slot_cnt[cur_slot] == '0 && slot_pc[cur_slot] == '0)
					found = pick_next_task();
			end
			OP_YIELD: begin
				slot_cnt[cur_slot] = '0;
				found = pick_next_task();
			end
			OP_PC_DIS: slot_pc[cur_slot] = pc_up(slot_pc[cur_slot]);
			OP_PC_EN:  slot_pc[cur_slot] = pc_down(slot_pc[cur_slot]);
			OP_ADD: begin
				if (!slot_run[slot]) begin
					slot_run[slot] = 1'b1;
					slot_pri[slot] = (pri == '0) ? PRI_W'(1) : pri;
					slot_cnt[slot] = CNT_W'(slot_pri[slot]);
					slot_pc[slot]  = PC_W'(1);
				end
			end
			OP_TERM: begin
				slot_pc[cur_slot]  = pc_up(slot_pc[cur_slot]);
				slot_run[cur_slot] = 1'b0;
				slot_pc[cur_slot]  = pc_down(slot_pc[cur_slot]);
			end
			default: ;
		endcase
		r.cur   = cur_slot;
		r.prev  = prev;
		r.sw    = (cur_slot != prev);
		r.found = found;
		return r;
	endfunction

	sched_result_t seen, want;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_TASKS; i++) begin
				slot_run[i] = 1'b0;
				slot_cnt[i] = '0;
				slot_pri[i] = '0;
				slot_pc[i]  = '0;
			end
			init_pri    = INIT_PRIO;
			slot_run[0] = 1'b1;
			slot_pri[0] = init_pri;
			cur_slot    = '0;
			expected_results.delete();
			fail_count <= 0;
			pending    <= 0;
		end else begin
			// priority register also reloads slot zero
			if (cfg_wr_en) begin
				init_pri    = cfg_wr_data;
				slot_pri[0] = cfg_wr_data;
			end
			// accepted request
			if (req.valid && req.ready)
				expected_results.push_back(schedule_step(req.opcode, req.task_slot,
					req.task_priority));
			// accepted result against oldest prediction
			if (rsp.valid && rsp.ready) begin
				seen = '{rsp.current_task, rsp.previous_task, rsp.switched,
					rsp.task_found};
				if (expected_results.size() == 0) begin
					fail_count <= fail_count + 1;
					$display("%0t: unexpected result, expected none, %s",
						$time, $sformatf("actual cur=%0d prev=%0d sw=%0b found=%0b",
						seen.cur, seen.prev, seen.sw, seen.found));
				end else begin
					want = expected_results.pop_front();
					if (seen !== want) begin
						fail_count <= fail_count + 1;
						$display("%0t: result mismatch, %s, %s", $time,
							$sformatf("expected cur=%0d prev=%0d sw=%0b found=%0b",
							want.cur, want.prev, want.sw, want.found),
							$sformatf("actual cur=%0d prev=%0d sw=%0b found=%0b",
							seen.cur, seen.prev, seen.sw, seen.found));
					end
				end
			end
			pending <= expected_results.size();
		end
	end

endmodule

// ===== tb/tb_counter_priority_task_scheduler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_counter_priority_task_scheduler
// Drives scheduler requests (directed corner cases, then random phases with
// different idle and stall mixes and priority settings) and gives the
// verdict from the failure count of the checker, or fail from a watchdog.
// ----------------------------------------------------------------------------
module tb_counter_priority_task_scheduler;
	import cpts_pkg::*;

	localparam logic [OP_W-1:0] OP_UNDEF_LO = 3'd6;
	localparam logic [OP_W-1:0] OP_UNDEF_HI = 3'd7;

	localparam int PHASES       = 4;
	localparam int PHASE_ITEMS  = 170;
	localparam int PC_BURST     = 258;
	localparam int HOLD_CYCLES  = 400;
	localparam int SETTLE       = 3 * MAX_TASKS + 4 + 8;
	localparam int WDOG_LIMIT   = 4000;

	logic             clk;
	logic             arst_n;
	logic             cfg_wr_en;
	logic [PRI_W-1:0] cfg_wr_data;
	int               fail_count;
	int               pending;

	int   send_idle_pct;
	int   recv_stall_pct;
	logic hold_req;

	cpts_req_if task_req_ch ();
	cpts_rsp_if sched_rsp_ch ();

	counter_priority_task_scheduler dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.task_req    (task_req_ch),
		.sched_rsp   (sched_rsp_ch),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	cpts_sched_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (task_req_ch),
		.rsp         (sched_rsp_ch),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.fail_count  (fail_count),
		.pending     (pending)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// result receiver, with an optional long hold-off
	initial begin
		sched_rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				sched_rsp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end
			sched_rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// watchdog on cycles without any handshake
	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WDOG_LIMIT) begin
			@(posedge clk);
			if ((task_req_ch.valid && task_req_ch.ready) ||
				(sched_rsp_ch.valid && sched_rsp_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("counter_priority_task_scheduler regression: fail");
		$finish;
	end

	// one request, with random idle cycles in front
	task automatic send_request(input logic [OP_W-1:0] op, input logic [SLOT_W-1:0] slot,
		input logic [PRI_W-1:0] pri);
		while ($urandom_range(99) < send_idle_pct) begin
			task_req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		task_req_ch.valid         <= 1'b1;
		task_req_ch.opcode        <= op;
		task_req_ch.task_slot     <= slot;
		task_req_ch.task_priority <= pri;
		@(posedge clk);
		while (!task_req_ch.ready) @(posedge clk);
	endtask

	// random request, ticks weighted to drive reschedules
	task automatic send_random();
		logic [OP_W-1:0] op;
		int r;
		r = $urandom_range(99);
		if (r < 34)      op = OP_TICK;
		else if (r < 50) op = OP_YIELD;
		else if (r < 60) op = OP_PC_DIS;
		else if (r < 70) op = OP_PC_EN;
		else if (r < 86) op = OP_ADD;
		else if (r < 94) op = OP_TERM;
		else if (r < 97) op = OP_UNDEF_LO;
		else             op = OP_UNDEF_HI;
		send_request(op, SLOT_W'($urandom_range(MAX_TASKS - 1)), PRI_W'($urandom_range(255)));
	endtask

	// stop offering and wait for every outstanding result
	task automatic wait_drained();
		task_req_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic write_priority(input logic [PRI_W-1:0] value);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
	endtask

	// stimulus and verdict
	initial begin
		arst_n                    = 1'b0;
		cfg_wr_en                 = 1'b0;
		cfg_wr_data               = '0;
		task_req_ch.valid         = 1'b0;
		task_req_ch.opcode        = OP_TICK;
		task_req_ch.task_slot     = '0;
		task_req_ch.task_priority = '0;
		send_idle_pct             = 0;
		recv_stall_pct            = 0;
		hold_req                  = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: refill from reset, preempt limits, adds, ties, empty table
		send_request(OP_TICK,     4'd0,  8'd0);
		send_request(OP_TICK,     4'd0,  8'd0);
		send_request(OP_PC_EN,    4'd0,  8'd0);
		send_request(OP_PC_DIS,   4'd0,  8'd0);
		send_request(OP_TICK,     4'd0,  8'd0);
		send_request(OP_PC_EN,    4'd0,  8'd0);
		send_request(OP_ADD,      4'd15, 8'd255);
		send_request(OP_ADD,      4'd15, 8'd7);
		send_request(OP_ADD,      4'd1,  8'd0);
		send_request(OP_YIELD,    4'd0,  8'd0);
		send_request(OP_UNDEF_LO, 4'd15, 8'd255);
		send_request(OP_UNDEF_HI, 4'd0,  8'd0);
		send_request(OP_TICK,     4'd0,  8'd0);
		send_request(OP_TERM,     4'd0,  8'd0);
		send_request(OP_YIELD,    4'd0,  8'd0);
		send_request(OP_TERM,     4'd0,  8'd0);
		send_request(OP_YIELD,    4'd0,  8'd0);
		send_request(OP_TERM,     4'd0,  8'd0);
		send_request(OP_TICK,     4'd0,  8'd0);
		send_request(OP_YIELD,    4'd0,  8'd0);
		send_request(OP_ADD,      4'd0,  8'd255);
		send_request(OP_ADD,      4'd3,  8'd200);
		send_request(OP_ADD,      4'd9,  8'd200);
		send_request(OP_YIELD,    4'd0,  8'd0);
		send_request(OP_TICK,     4'd0,  8'd0);

		// random phases: none, sender idle, receiver stall, both
		for (int ph = 0; ph < PHASES; ph++) begin
			wait_drained();
			repeat (SETTLE) @(posedge clk);
			case (ph)
				0:       write_priority(8'd255);
				1:       write_priority(8'd1);
				default: write_priority(PRI_W'($urandom_range(255, 1)));
			endcase
			case (ph)
				0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1:       begin send_idle_pct = 56; recv_stall_pct = 0;  end
				2:       begin send_idle_pct = 0;  recv_stall_pct = 56; end
				default: begin send_idle_pct = 38; recv_stall_pct = 38; end
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// back-pressure: receiver holds off while requests keep coming
				if (ph == 0 && n == 60)
					hold_req = 1'b1;
				// preempt count pushed into saturation
				if (ph == 0 && n == 100)
					repeat (PC_BURST) send_request(OP_PC_DIS,
						SLOT_W'($urandom_range(MAX_TASKS - 1)), PRI_W'($urandom_range(255)));
				// sender pauses until everything is back
				if (ph == 1 && n == 80)
					wait_drained();
				send_random();
			end
		end

		wait_drained();
		repeat (SETTLE) @(posedge clk);
		if (fail_count == 0)
			$display("counter_priority_task_scheduler regression: pass");
		else
			$display("counter_priority_task_scheduler regression: fail");
		$finish;
	end

endmodule
